// File: src/cpm_pkg.sv
// Package for the CIGAR position mapper: position width, op codes,
// item and state types shared by the step logic and the top level.
// No dependencies.
`default_nettype none
package cpm_pkg;

	localparam int POS_W = 32;

	typedef logic [POS_W-1:0] pos_t;

	typedef enum logic [3:0] {
		OP_M    = 4'd0,
		OP_EQ   = 4'd1,
		OP_X    = 4'd2,
		OP_I    = 4'd3,
		OP_S    = 4'd4,
		OP_D    = 4'd5,
		OP_N    = 4'd6,
		OP_H    = 4'd7,
		OP_P    = 4'd8,
		OP_NONE = 4'd9
	} op_code_t;

	typedef struct packed {
		logic               first_op;
		logic signed [31:0] start_pos;
		logic [30:0]        leftmost_pos;
		logic               snap_left;
		logic [3:0]         op_code;
		logic [27:0]        op_length;
		logic               last_op;
	} op_item_t;

	typedef struct packed {
		pos_t target;
		pos_t running;
		pos_t consumed;
		logic reached;
		logic narrow_side;
	} map_state_t;

endpackage
`default_nettype wire

// File: src/cpm_ifs.sv
// Channel interfaces of the CIGAR position mapper: op input, result output
// and the mapping_direction write port. No dependencies.
`default_nettype none
interface cpm_op_if;
	logic               valid;
	logic               ready;
	logic               first_op;
	logic signed [31:0] start_pos;
	logic [30:0]        leftmost_pos;
	logic               snap_left;
	logic [3:0]         op_code;
	logic [27:0]        op_length;
	logic               last_op;

	modport source (output valid, first_op, start_pos, leftmost_pos, snap_left,
		op_code, op_length, last_op, input ready);
	modport sink (input valid, first_op, start_pos, leftmost_pos, snap_left,
		op_code, op_length, last_op, output ready);
endinterface

interface cpm_res_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] mapped_pos;
	logic               mapped_valid;

	modport source (output valid, mapped_pos, mapped_valid, input ready);
	modport sink (input valid, mapped_pos, mapped_valid, output ready);
endinterface

interface cpm_cfg_if;
	logic valid;
	logic ready;
	logic data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface
`default_nettype wire

// File: src/cpm_step.sv
// Combinational update of the mapper state for one CIGAR op, including the
// load on the first op of an alignment and the result flag. Depends on cpm_pkg.
`default_nettype none
module cpm_step (
	input  logic                  dir,
	input  cpm_pkg::map_state_t   cur,
	input  cpm_pkg::op_item_t     item,
	output cpm_pkg::map_state_t   nxt,
	output logic                  ok
);
	import cpm_pkg::*;

	map_state_t ld;
	pos_t       s_ext;
	pos_t       lm_ext;
	pos_t       len;
	pos_t       gap;
	logic       reached0;
	logic       len_lt_gap;

	always_comb begin
		s_ext  = POS_W'(item.start_pos);
		lm_ext = POS_W'(item.leftmost_pos);
		len    = POS_W'(item.op_length);

		ld = cur;
		if (item.first_op) begin
			ld.target      = s_ext;
			ld.running     = dir ? (s_ext - lm_ext + pos_t'(1)) : (s_ext + lm_ext - pos_t'(1));
			ld.consumed    = '0;
			ld.narrow_side = item.snap_left;
		end
		reached0 = !($signed(ld.consumed) < $signed(dir ? ld.running : ld.target));

		gap        = dir ? (ld.running - ld.consumed) : (ld.target - ld.consumed);
		len_lt_gap = $signed(len) < $signed(gap);

		nxt = ld;
		if (!reached0) begin
			if (!dir) begin
				case (item.op_code)
					OP_M, OP_EQ, OP_X, OP_S: begin
						nxt.consumed = ld.consumed + len;
					end
					OP_I: begin
						if (len_lt_gap)
							nxt.running = ld.running - len;
						else
							nxt.running = ld.running - gap + pos_t'(!ld.narrow_side);
						nxt.consumed = ld.consumed + len;
					end
					OP_D, OP_N: begin
						nxt.running = ld.running + len;
					end
					default: ;
				endcase
			end else begin
				case (item.op_code)
					OP_M, OP_EQ, OP_X: begin
						nxt.consumed = ld.consumed + len;
					end
					OP_I, OP_S: begin
						nxt.running  = ld.running + len;
						nxt.consumed = ld.consumed + len;
					end
					OP_D, OP_N: begin
						if (len_lt_gap)
							nxt.running = ld.running - len;
						else
							nxt.running = ld.consumed + pos_t'(!ld.narrow_side);
					end
					default: ;
				endcase
			end
		end
		nxt.reached = !($signed(nxt.consumed) < $signed(dir ? nxt.running : nxt.target));

		ok = nxt.reached;
		if (dir && (nxt.running == '0 || nxt.running[POS_W-1]))
			ok = 1'b0;
	end
endmodule
`default_nettype wire

// File: src/cigar_position_mapper.sv
// Top level of the CIGAR position mapper: input register, step logic and
// result register. Depends on cpm_pkg, cpm_ifs and cpm_step.
//
// One CIGAR op is taken per clock cycle while no last_op waits on a stalled
// result. Each op is registered, then the state (target, running position,
// consumed count) is updated by one pass of adders and signed compares in
// cpm_step, so the next op may follow immediately. The op marked last_op loads
// the result register on the edge where it leaves the input register, so its
// result transaction is offered from the next cycle. A stalled result only
// holds back the next last_op. The mapping_direction register is written
// through the cfg port, which is ready only while the input register is empty.
`default_nettype none
module cigar_position_mapper (
	input  logic      clk,
	input  logic      arst_n,
	cpm_op_if.sink    op,
	cpm_res_if.source res,
	cpm_cfg_if.sink   cfg
);
	import cpm_pkg::*;

	logic       dir_q;
	map_state_t st_q;
	map_state_t st_nxt;
	op_item_t   item_s1;
	op_item_t   item_in;
	logic       valid_s1;
	logic       adv;
	logic       ok;
	logic       out_valid_q;
	logic [31:0] out_pos_q;
	logic       out_ok_q;

	assign item_in = '{first_op: op.first_op, start_pos: op.start_pos,
		leftmost_pos: op.leftmost_pos, snap_left: op.snap_left,
		op_code: op.op_code, op_length: op.op_length, last_op: op.last_op};

	assign adv      = valid_s1 && (!item_s1.last_op || !out_valid_q || res.ready);
	assign op.ready = !valid_s1 || adv;
	assign cfg.ready = !valid_s1;

	cpm_step u_step (
		.dir  (dir_q),
		.cur  (st_q),
		.item (item_s1),
		.nxt  (st_nxt),
		.ok   (ok)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dir_q       <= 1'b0;
			st_q        <= '0;
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg.valid && cfg.ready)
				dir_q <= cfg.data;
			if (op.ready)
				valid_s1 <= op.valid;
			if (adv)
				st_q <= st_nxt;
			if (adv && item_s1.last_op)
				out_valid_q <= 1'b1;
			else if (res.ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (op.ready && op.valid)
			item_s1 <= item_in;
		if (adv && item_s1.last_op) begin
			out_pos_q <= ok ? 32'(st_nxt.running) : 32'd0;
			out_ok_q  <= ok;
		end
	end

	assign res.valid        = out_valid_q;
	assign res.mapped_pos   = $signed(out_pos_q);
	assign res.mapped_valid = out_ok_q;

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		adv && item_s1.last_op |=> out_valid_q)
		else $error("last op did not produce a result");

	a_na_is_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_ok_q |-> out_pos_q == 32'd0)
		else $error("unmappable result carries a nonzero position");

	a_valid_needs_reached: assert property (@(posedge clk) disable iff (!arst_n)
		adv && item_s1.last_op |=> (!out_ok_q || st_q.reached))
		else $error("valid result without the target reached");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !res.ready |-> !(adv && item_s1.last_op))
		else $error("pending result overwritten");
endmodule
`default_nettype wire

// File: dv/cpm_map_checker.sv
// Checker for cigar_position_mapper: watches the op, result and cfg channels,
// predicts every mapped position and compares each result transaction.
// Depends on cpm_pkg and cpm_ifs.
module cpm_map_checker (
	input  logic clk,
	input  logic arst_n,
	cpm_op_if    op,
	cpm_res_if   res,
	cpm_cfg_if   cfg,
	output int   fail_count,
	output int   pending
);
	timeunit 1ns;
	timeprecision 1ps;
	import cpm_pkg::*;

	typedef struct packed {
		logic signed [31:0] pos;
		logic               ok;
	} map_result_t;

	map_result_t expected_maps[$];
	logic        dir;
	pos_t        tgt_pos;
	pos_t        run_pos;
	pos_t        used_cnt;
	logic        narrow;

	function automatic logic target_reached();
		pos_t lim;
		lim = dir ? run_pos : tgt_pos;
		return !($signed(used_cnt) < $signed(lim));
	endfunction

	function automatic logic map_op(input op_item_t it, output map_result_t r);
		pos_t len;
		pos_t gap;
		logic hit;
		len = pos_t'(it.op_length);
		if (it.first_op) begin
			tgt_pos = pos_t'(it.start_pos);
			if (dir)
				run_pos = pos_t'(it.start_pos) - pos_t'(it.leftmost_pos) + 1;
			else
				run_pos = pos_t'(it.start_pos) + pos_t'(it.leftmost_pos) - 1;
			used_cnt = '0;
			narrow = it.snap_left;
		end
		if (!target_reached()) begin
			if (!dir) begin
				case (it.op_code)
				OP_M, OP_EQ, OP_X, OP_S: used_cnt = used_cnt + len;
				OP_I: begin
					gap = tgt_pos - used_cnt;
					if ($signed(len) < $signed(gap))
						run_pos = run_pos - len;
					else
						run_pos = run_pos - gap + (narrow ? 0 : 1);
					used_cnt = used_cnt + len;
				end
				OP_D, OP_N: run_pos = run_pos + len;
				default: ;
				endcase
			end else begin
				case (it.op_code)
				OP_M, OP_EQ, OP_X: used_cnt = used_cnt + len;
				OP_I, OP_S: begin
					run_pos = run_pos + len;
					used_cnt = used_cnt + len;
				end
				OP_D, OP_N: begin
					gap = run_pos - used_cnt;
					if ($signed(len) < $signed(gap))
						run_pos = run_pos - len;
					else
						run_pos = used_cnt + (narrow ? 0 : 1);
				end
				default: ;
				endcase
			end
		end
		hit = target_reached();
		if (dir && (run_pos == '0 || run_pos[POS_W-1]))
			hit = 1'b0;
		r.ok = hit;
		r.pos = hit ? run_pos[31:0] : '0;
		return it.last_op;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		op_item_t    it;
		map_result_t r;
		map_result_t want;
		if (!arst_n) begin
			dir = 1'b0;
			tgt_pos = '0;
			run_pos = '0;
			used_cnt = '0;
			narrow = 1'b0;
			expected_maps.delete();
			fail_count = 0;
			pending = 0;
		end else begin
			if (cfg.valid && cfg.ready)
				dir = cfg.data;
			if (res.valid && res.ready) begin
				if (expected_maps.size() == 0) begin
					$display("%0t: unexpected result transaction: pos %0d valid %0b",
						$time, res.mapped_pos, res.mapped_valid);
					fail_count++;
				end else begin
					want = expected_maps.pop_front();
					if (res.mapped_pos !== want.pos) begin
						$display("%0t: mapped_pos expected %0d, got %0d",
							$time, want.pos, res.mapped_pos);
						fail_count++;
					end
					if (res.mapped_valid !== want.ok) begin
						$display("%0t: mapped_valid expected %0b, got %0b",
							$time, want.ok, res.mapped_valid);
						fail_count++;
					end
				end
			end
			if (op.valid && op.ready) begin
				it.first_op = op.first_op;
				it.start_pos = op.start_pos;
				it.leftmost_pos = op.leftmost_pos;
				it.snap_left = op.snap_left;
				it.op_code = op.op_code;
				it.op_length = op.op_length;
				it.last_op = op.last_op;
				if (map_op(it, r))
					expected_maps.push_back(r);
			end
			pending = expected_maps.size();
		end
	end

endmodule

// File: dv/cigar_position_mapper_test.sv
// Testbench top for cigar_position_mapper: clock, reset, directed and random
// CIGAR op streams with random idling, and the verdict. Depends on cpm_pkg,
// cpm_ifs, the RTL and cpm_map_checker.
module cigar_position_mapper_test;
	timeunit 1ns;
	timeprecision 1ps;
	import cpm_pkg::*;

	localparam logic [3:0] OP_UNUSED_TOP = 4'hF;
	localparam int PHASE_OPS = 219;

	logic clk;
	logic arst_n;
	logic no_gaps;
	int   fail_count;
	int   pending;
	int   ops_sent;

	cpm_op_if  op_ch ();
	cpm_res_if res_ch ();
	cpm_cfg_if cfg_ch ();

	cigar_position_mapper dut (
		.clk   (clk),
		.arst_n(arst_n),
		.op    (op_ch),
		.res   (res_ch),
		.cfg   (cfg_ch)
	);

	cpm_map_checker mapping_check (
		.clk       (clk),
		.arst_n    (arst_n),
		.op        (op_ch),
		.res       (res_ch),
		.cfg       (cfg_ch),
		.fail_count(fail_count),
		.pending   (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#10_000_000;
		$display("TEST FAILED");
		$finish;
	end

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (no_gaps)
			return 0;
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	function automatic op_item_t make_op(logic first, logic [31:0] start, logic [30:0] lm,
		logic nl, logic [3:0] code, logic [27:0] len, logic last);
		op_item_t it;
		it.first_op = first;
		it.start_pos = start;
		it.leftmost_pos = lm;
		it.snap_left = nl;
		it.op_code = code;
		it.op_length = len;
		it.last_op = last;
		return it;
	endfunction

	function automatic op_item_t rand_item();
		op_item_t it;
		it.first_op = 1'($urandom_range(0, 1));
		it.start_pos = $urandom;
		it.leftmost_pos = 31'($urandom);
		it.snap_left = 1'($urandom_range(0, 1));
		it.op_code = 4'($urandom_range(0, 15));
		it.op_length = 28'($urandom);
		it.last_op = 1'($urandom_range(0, 1));
		return it;
	endfunction

	function automatic logic [3:0] pick_op();
		int r;
		r = $urandom_range(0, 99);
		if (r < 20) return OP_M;
		if (r < 30) return OP_EQ;
		if (r < 40) return OP_X;
		if (r < 55) return OP_I;
		if (r < 68) return OP_S;
		if (r < 80) return OP_D;
		if (r < 90) return OP_N;
		if (r < 94) return OP_H;
		if (r < 97) return OP_P;
		if (r < 98) return OP_NONE;
		return 4'($urandom_range(int'(OP_NONE) + 1, int'(OP_UNUSED_TOP)));
	endfunction

	// called at a falling edge, returns at the falling edge after acceptance
	task automatic send_op(input op_item_t it);
		int g;
		g = gap_len();
		if (g > 0) begin
			op_ch.valid = 1'b0;
			repeat (g) @(negedge clk);
		end
		op_ch.valid = 1'b1;
		op_ch.first_op = it.first_op;
		op_ch.start_pos = it.start_pos;
		op_ch.leftmost_pos = it.leftmost_pos;
		op_ch.snap_left = it.snap_left;
		op_ch.op_code = it.op_code;
		op_ch.op_length = it.op_length;
		op_ch.last_op = it.last_op;
		do @(posedge clk); while (!op_ch.ready);
		ops_sent++;
		@(negedge clk);
	endtask

	task automatic write_direction(input logic d);
		op_ch.valid = 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
		cfg_ch.valid = 1'b1;
		cfg_ch.data = d;
		do @(posedge clk); while (!cfg_ch.ready);
		@(negedge clk);
		cfg_ch.valid = 1'b0;
	endtask

	// mostly well-formed alignment; a few lose the load or the closing op
	task automatic send_alignment(input logic d);
		op_item_t    it;
		int          n;
		logic [31:0] offs;
		logic [31:0] start;
		logic [30:0] lm;
		n = $urandom_range(1, 8);
		lm = ($urandom_range(0, 9) == 0) ? 31'($urandom) : 31'($urandom_range(1, 1000));
		case ($urandom_range(0, 9))
		0: offs = $urandom;
		1: offs = -$urandom_range(0, 3);
		default: offs = $urandom_range(1, 100);
		endcase
		start = d ? offs + lm - 1 : offs;
		for (int k = 0; k < n; k++) begin
			it = rand_item();
			it.first_op = (k == 0) && ($urandom_range(0, 19) != 0);
			if (k == 0) begin
				it.start_pos = start;
				it.leftmost_pos = lm;
			end
			it.op_code = pick_op();
			if ($urandom_range(0, 49) != 0)
				it.op_length = 28'($urandom_range(0, 40));
			it.last_op = (k == n - 1) && ($urandom_range(0, 19) != 0);
			send_op(it);
		end
	endtask

	initial begin
		int stall;
		stall = 0;
		res_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (no_gaps || stall == 0) begin
				res_ch.ready = 1'b1;
				if ($urandom_range(0, 3) == 0)
					stall = gap_len();
			end else begin
				res_ch.ready = 1'b0;
				stall--;
			end
		end
	end

	initial begin
		int phase_end;
		op_ch.valid = 1'b0;
		op_ch.first_op = 1'b0;
		op_ch.start_pos = '0;
		op_ch.leftmost_pos = '0;
		op_ch.snap_left = 1'b0;
		op_ch.op_code = OP_M;
		op_ch.op_length = '0;
		op_ch.last_op = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.data = 1'b0;
		no_gaps = 1'b0;
		ops_sent = 0;
		arst_n = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// read to reference; first op works on the reset state
		send_op(make_op(0, 0, 0, 0, OP_M, 5, 1));
		send_op(make_op(1, 10, 100, 0, OP_S, 3, 0));
		send_op(make_op(0, 0, 0, 0, OP_I, 4, 0));
		send_op(make_op(0, 0, 0, 0, OP_M, 20, 1));
		send_op(make_op(1, 5, 1000, 1, OP_M, 3, 0));
		send_op(make_op(0, 0, 0, 0, OP_I, 10, 1));
		send_op(make_op(1, 8, 1, 0, OP_M, 4, 0));
		send_op(make_op(0, 0, 0, 0, OP_N, 5, 0));
		send_op(make_op(0, 0, 0, 0, OP_D, 10, 1));
		send_op(make_op(1, 0, 7, 0, OP_M, 5, 1));
		send_op(make_op(1, 32'h8000_0000, 31'h7FFF_FFFF, 1, OP_M, 5, 1));
		send_op(make_op(1, 100, 1, 0, OP_M, 10, 1));
		send_op(make_op(1, 3, 50, 0, OP_H, 5, 0));
		send_op(make_op(0, 0, 0, 0, OP_P, 2, 0));
		send_op(make_op(0, 0, 0, 0, OP_NONE, 0, 0));
		send_op(make_op(0, 0, 0, 0, OP_UNUSED_TOP, 7, 0));
		send_op(make_op(0, 0, 0, 0, OP_M, 5, 1));
		send_op(make_op(1, 32'h7FFF_FFFF, 31'h7FFF_FFFF, 1, OP_M, 28'hFFF_FFFF, 1));

		// reference to read: gap narrowing and nonpositive positions
		write_direction(1'b1);
		send_op(make_op(1, 150, 100, 0, OP_M, 20, 0));
		send_op(make_op(0, 0, 0, 0, OP_D, 10, 0));
		send_op(make_op(0, 0, 0, 0, OP_I, 5, 1));
		send_op(make_op(1, 120, 100, 1, OP_M, 10, 0));
		send_op(make_op(0, 0, 0, 0, OP_D, 30, 1));
		send_op(make_op(1, 50, 100, 0, OP_M, 5, 1));
		send_op(make_op(1, 99, 100, 0, OP_M, 5, 1));

		for (int p = 0; p < 8; p++) begin
			write_direction(p[0]);
			no_gaps = (p == 2 || p == 5);
			phase_end = ops_sent + PHASE_OPS;
			while (ops_sent < phase_end) begin
				if ($urandom_range(0, 9) == 0)
					send_op(rand_item());
				else
					send_alignment(p[0]);
			end
		end
		no_gaps = 1'b0;

		op_ch.valid = 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (10) @(negedge clk);
		if (fail_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
